// ===== src/sotq_pkg.sv =====
// ----------------------------------------------------------------------------
// sotq_pkg
// Types, codes and command/status bundles of the sorted one-shot timer queue.
// ----------------------------------------------------------------------------
package sotq_pkg;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  timer_index;
    logic [31:0] delay_ticks;
    logic [31:0] tag_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [5:0]  slot_index;
    logic [31:0] tag_out;
    logic        last_result;
  } out_item_t;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_ALLOC  = 3'd1;
  localparam logic [2:0] REQ_ARM    = 3'd2;
  localparam logic [2:0] REQ_CANCEL = 3'd3;
  localparam logic [2:0] REQ_FREE   = 3'd4;

  localparam logic [2:0] KIND_EXPIRY      = 3'd0;
  localparam logic [2:0] KIND_TASK_SWITCH = 3'd1;
  localparam logic [2:0] KIND_ALLOCATED   = 3'd2;
  localparam logic [2:0] KIND_ALLOC_FAIL  = 3'd3;
  localparam logic [2:0] KIND_CANCELLED   = 3'd4;
  localparam logic [2:0] KIND_NOT_RUNNING = 3'd5;
  localparam logic [2:0] KIND_DONE        = 3'd6;

  localparam logic [6:0]  LIST_END  = 7'd64;
  localparam logic [6:0]  TASK_NONE = 7'd64;
  localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

  typedef struct packed {
    logic       latch_req;
    logic       tick_inc;
    logic       calc_dl;
    logic       load_cur_head;
    logic       rd_cur;
    logic       step;
    logic       ul_fix;
    logic       wr_dltag;
    logic       ins_self;
    logic       ins_prev;
    logic       fire;
    logic       tick_end;
    logic       scan_clr;
    logic       scan_inc;
    logic       emit;
    logic [2:0] emit_kind;
    logic       set_alloc;
    logic       clr_alloc;
    logic       set_run;
    logic       clr_run;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       idx_ok;
    logic       idx_alloc;
    logic       idx_run;
    logic       cur_in_list;
    logic       cur_is_idx;
    logic       dl_le;
    logic       fire_ok;
    logic       scan_done;
    logic       scan_free;
    logic       out_free;
  } sts_t;

endpackage

// ===== src/sotq_ram.sv =====
// ----------------------------------------------------------------------------
// sotq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sotq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sotq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sotq_ctrl
// Request sequencer: list walks for unlink, insert and tick expiry, free-slot
// scan, and result hand-off.
// ----------------------------------------------------------------------------
module sotq_ctrl
  import sotq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_UL_RD   = 4'd2;
  localparam logic [3:0] S_UL_WAIT = 4'd3;
  localparam logic [3:0] S_UL_FIX  = 4'd4;
  localparam logic [3:0] S_INS_WR  = 4'd5;
  localparam logic [3:0] S_INS_RD  = 4'd6;
  localparam logic [3:0] S_INS_WT  = 4'd7;
  localparam logic [3:0] S_INS_SLF = 4'd8;
  localparam logic [3:0] S_INS_PRV = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;
  localparam logic [3:0] S_T_RD    = 4'd11;
  localparam logic [3:0] S_T_WAIT  = 4'd12;
  localparam logic [3:0] S_T_END   = 4'd13;
  localparam logic [3:0] S_A_SCAN  = 4'd14;

  logic [3:0] state_q, state_d;
  logic [2:0] kind_q, kind_d;
  logic       upd_q, upd_d;
  logic [3:0] after_ul;

  assign in_ready_o = (state_q == S_IDLE);
  assign after_ul   = (sts_i.req_type == REQ_ARM) ? S_INS_WR : S_FIN;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    upd_d   = upd_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        kind_d = KIND_DONE;
        upd_d  = 1'b0;
        state_d = S_FIN;
        case (sts_i.req_type)
          REQ_TICK: begin
            cmd_o.tick_inc      = 1'b1;
            cmd_o.load_cur_head = 1'b1;
            state_d = S_T_RD;
          end
          REQ_ALLOC: begin
            cmd_o.scan_clr = 1'b1;
            state_d = S_A_SCAN;
          end
          REQ_ARM: begin
            if (sts_i.idx_ok && sts_i.idx_alloc) begin
              cmd_o.calc_dl       = 1'b1;
              cmd_o.load_cur_head = 1'b1;
              upd_d = 1'b1;
              state_d = sts_i.idx_run ? S_UL_RD : S_INS_WR;
            end
          end
          REQ_CANCEL: begin
            if (sts_i.idx_ok && sts_i.idx_run) begin
              cmd_o.load_cur_head = 1'b1;
              kind_d = KIND_CANCELLED;
              upd_d  = 1'b1;
              state_d = S_UL_RD;
            end else begin
              kind_d = KIND_NOT_RUNNING;
            end
          end
          REQ_FREE: begin
            if (sts_i.idx_ok) begin
              upd_d = 1'b1;
              if (sts_i.idx_run) begin
                cmd_o.load_cur_head = 1'b1;
                state_d = S_UL_RD;
              end
            end
          end
          default: ;
        endcase
      end
      S_UL_RD: begin
        if (!sts_i.cur_in_list) begin
          state_d = after_ul;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = sts_i.cur_is_idx ? S_UL_FIX : S_UL_WAIT;
        end
      end
      S_UL_WAIT: begin
        cmd_o.step = 1'b1;
        state_d = S_UL_RD;
      end
      S_UL_FIX: begin
        cmd_o.ul_fix = 1'b1;
        state_d = after_ul;
      end
      S_INS_WR: begin
        cmd_o.wr_dltag      = 1'b1;
        cmd_o.load_cur_head = 1'b1;
        state_d = S_INS_RD;
      end
      S_INS_RD: begin
        if (!sts_i.cur_in_list) begin
          state_d = S_INS_SLF;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = S_INS_WT;
        end
      end
      S_INS_WT: begin
        if (sts_i.dl_le) begin
          state_d = S_INS_SLF;
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_INS_RD;
        end
      end
      S_INS_SLF: begin
        cmd_o.ins_self = 1'b1;
        state_d = S_INS_PRV;
      end
      S_INS_PRV: begin
        // slot turns running as it becomes reachable from the list
        cmd_o.ins_prev = 1'b1;
        cmd_o.set_run  = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = kind_q;
          if (upd_q) begin
            case (sts_i.req_type)
              REQ_ALLOC:  cmd_o.set_alloc = 1'b1;
              REQ_CANCEL: cmd_o.clr_run   = 1'b1;
              REQ_FREE: begin
                cmd_o.clr_run   = 1'b1;
                cmd_o.clr_alloc = 1'b1;
              end
              default: ;
            endcase
          end
          state_d = S_IDLE;
        end
      end
      S_T_RD: begin
        if (!sts_i.cur_in_list) begin
          state_d = S_T_END;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        if (!sts_i.fire_ok) begin
          state_d = S_T_END;
        end else if (sts_i.out_free) begin
          cmd_o.fire = 1'b1;
          state_d = S_T_RD;
        end
      end
      S_T_END: begin
        if (sts_i.out_free) begin
          cmd_o.tick_end = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_A_SCAN: begin
        if (sts_i.scan_done) begin
          kind_d = KIND_ALLOC_FAIL;
          upd_d  = 1'b0;
          state_d = S_FIN;
        end else if (sts_i.scan_free) begin
          kind_d = KIND_ALLOCATED;
          upd_d  = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_DONE;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      upd_q   <= upd_d;
    end
  end

endmodule

// ===== src/sotq_dp.sv =====
// ----------------------------------------------------------------------------
// sotq_dp
// Datapath: tick count, list head, slot status bits, slot RAMs, walk
// pointers and the result registers.
// ----------------------------------------------------------------------------
module sotq_dp
  import sotq_pkg::*;
#(
  parameter int NUM_TIMERS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  logic       cfg_valid_i,
  input  logic [6:0] cfg_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o,
  input  cmd_t       cmd_i,
  output sts_t       sts_o
);

  localparam int USABLE = (NUM_TIMERS < 64) ? NUM_TIMERS : 64;
  localparam int SW     = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam int CW     = $clog2(USABLE + 1);

  in_item_t          req_q;
  logic [31:0]       count_q, count_d;
  logic [6:0]        head_q, head_d;
  logic [6:0]        task_q;
  logic [USABLE-1:0] alloc_q, alloc_d, run_q, run_d;
  logic [6:0]        cur_q, prev_q;
  logic [31:0]       dl_q;
  logic [CW-1:0]     scan_q;
  logic              pend_valid_q, pend_valid_d;
  logic [2:0]        pend_kind_q;
  logic [5:0]        pend_slot_q;
  logic [31:0]       pend_tag_q;
  logic              out_valid_q, out_valid_d, out_load;
  out_item_t         out_q, out_d;

  logic [SW-1:0] idx_a, cur_a, prev_a, scan_a;
  logic [32:0]   dl_sum;
  logic [31:0]   dl_rd, tag_rd;
  logic [6:0]    nx_rd;
  logic          nx_we;
  logic [SW-1:0] nx_waddr;
  logic [6:0]    nx_wdata;

  assign idx_a  = req_q.timer_index[SW-1:0];
  assign cur_a  = cur_q[SW-1:0];
  assign prev_a = prev_q[SW-1:0];
  assign scan_a = scan_q[SW-1:0];
  assign dl_sum = {1'b0, count_q} + {1'b0, req_q.delay_ticks};

  // slot RAMs, all read at the walk pointer
  sotq_ram #(.WIDTH(32), .DEPTH(USABLE)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_dltag),
    .waddr_i (idx_a),
    .wdata_i (dl_q),
    .re_i    (cmd_i.rd_cur),
    .raddr_i (cur_a),
    .rdata_o (dl_rd)
  );

  sotq_ram #(.WIDTH(32), .DEPTH(USABLE)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_dltag),
    .waddr_i (idx_a),
    .wdata_i (req_q.tag_value),
    .re_i    (cmd_i.rd_cur),
    .raddr_i (cur_a),
    .rdata_o (tag_rd)
  );

  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = prev_a;
    nx_wdata = nx_rd;
    if (cmd_i.ul_fix && prev_q != LIST_END) begin
      nx_we = 1'b1;
    end
    if (cmd_i.ins_self) begin
      nx_we    = 1'b1;
      nx_waddr = idx_a;
      nx_wdata = cur_q;
    end
    if (cmd_i.ins_prev && prev_q != LIST_END) begin
      nx_we    = 1'b1;
      nx_wdata = {1'b0, req_q.timer_index};
    end
  end

  sotq_ram #(.WIDTH(7), .DEPTH(USABLE)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .re_i    (cmd_i.rd_cur),
    .raddr_i (cur_a),
    .rdata_o (nx_rd)
  );

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    alloc_d = alloc_q;
    run_d   = run_q;
    if (cmd_i.tick_inc) count_d = count_q + 32'd1;
    if (cmd_i.tick_end && count_q == ALL_ONES) count_d = '0;
    if (cmd_i.ul_fix && prev_q == LIST_END) head_d = nx_rd;
    if (cmd_i.ins_prev && prev_q == LIST_END) head_d = {1'b0, req_q.timer_index};
    if (cmd_i.fire) head_d = nx_rd;
    if (cmd_i.set_alloc) alloc_d[scan_a] = 1'b1;
    if (cmd_i.clr_alloc) alloc_d[idx_a] = 1'b0;
    if (cmd_i.set_run) run_d[idx_a] = 1'b1;
    if (cmd_i.clr_run) run_d[idx_a] = 1'b0;
    if (cmd_i.fire) run_d[cur_a] = 1'b0;
  end

  // one held-back expiry so the final one can carry the last flag
  assign out_load = cmd_i.emit | cmd_i.tick_end | (cmd_i.fire & pend_valid_q);

  always_comb begin
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
    if (cmd_i.fire) begin
      pend_valid_d = 1'b1;
      out_d = '{result_kind: pend_kind_q, slot_index: pend_slot_q,
                tag_out: pend_tag_q, last_result: 1'b0};
    end
    if (cmd_i.tick_end) begin
      pend_valid_d = 1'b0;
      if (pend_valid_q) begin
        out_d = '{result_kind: pend_kind_q, slot_index: pend_slot_q,
                  tag_out: pend_tag_q, last_result: 1'b1};
      end else begin
        out_d = '{result_kind: KIND_DONE, slot_index: 6'd0,
                  tag_out: 32'd0, last_result: 1'b1};
      end
    end
    if (cmd_i.emit) begin
      out_d = '{result_kind: cmd_i.emit_kind,
                slot_index: (cmd_i.emit_kind == KIND_ALLOCATED) ? 6'(scan_q) : 6'd0,
                tag_out: 32'd0, last_result: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      head_q       <= LIST_END;
      task_q       <= TASK_NONE;
      alloc_q      <= '0;
      run_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      head_q       <= head_d;
      alloc_q      <= alloc_d;
      run_q        <= run_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) task_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.latch_req) req_q <= in_data_i;
    if (cmd_i.calc_dl) dl_q <= dl_sum[32] ? ALL_ONES : dl_sum[31:0];
    if (cmd_i.load_cur_head) begin
      cur_q  <= head_q;
      prev_q <= LIST_END;
    end
    if (cmd_i.step) begin
      prev_q <= cur_q;
      cur_q  <= nx_rd;
    end
    if (cmd_i.fire) begin
      cur_q       <= nx_rd;
      pend_slot_q <= cur_q[5:0];
      if (cur_q == task_q) begin
        pend_kind_q <= KIND_TASK_SWITCH;
        pend_tag_q  <= 32'd0;
      end else begin
        pend_kind_q <= KIND_EXPIRY;
        pend_tag_q  <= tag_rd;
      end
    end
    if (cmd_i.scan_clr) scan_q <= '0;
    if (cmd_i.scan_inc) scan_q <= scan_q + CW'(1);
  end

  assign sts_o.req_type    = req_q.req_type;
  assign sts_o.idx_ok      = ({1'b0, req_q.timer_index} < 7'(USABLE));
  assign sts_o.idx_alloc   = alloc_q[idx_a];
  assign sts_o.idx_run     = run_q[idx_a];
  assign sts_o.cur_in_list = (cur_q < 7'(USABLE));
  assign sts_o.cur_is_idx  = (cur_q == {1'b0, req_q.timer_index});
  assign sts_o.dl_le       = (dl_q <= dl_rd);
  assign sts_o.fire_ok     = (dl_rd <= count_q);
  assign sts_o.scan_done   = (scan_q == CW'(USABLE));
  assign sts_o.scan_free   = !alloc_q[scan_a];
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_run_is_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q & ~alloc_q) == '0)
    else $error("running slot not allocated");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == LIST_END) || (head_q < 7'(USABLE)))
    else $error("list head out of range");

  a_head_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < 7'(USABLE)) |-> run_q[head_q[SW-1:0]])
    else $error("list head not running");

  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_end |=> !pend_valid_q)
    else $error("held expiry survives end of tick");

endmodule

// ===== src/sorted_oneshot_timer_queue.sv =====
// A tick walks the list from the head, one expired timer at a time; allocate scans
// the slots in order for a free one; cancel and free walk the list up to the slot;
// arm unlinks a running slot the same way, then walks the list to its insertion
// point. One item in flight at a time; the list walks over the slot RAMs (one read
// per entry) set the rate.
// Reset clears count, list head and all slot status at once; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_oneshot_timer_queue
// Pool of one-shot timers kept in a deadline-sorted linked list.
// ----------------------------------------------------------------------------
module sorted_oneshot_timer_queue
  import sotq_pkg::*;
#(
  parameter int NUM_TIMERS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sotq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sotq_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
